// ===== rtl/core/pps_pkg.sv =====
// shared types and constants for the preemptive priority scheduler core
// no dependencies; used by every module in rtl/core

package pps_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int ARRIVAL_W = 16;
  localparam int BURST_W   = 8;
  localparam int PRIO_W    = 8;
  localparam int INDEX_W   = 4;
  localparam int TICK_W    = 17;
  localparam int SUM_W     = 22;
  localparam int IDLE_W    = 16;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [ARRIVAL_W-1:0] arrival_tick;
    logic [BURST_W-1:0]   burst_ticks;
    logic [PRIO_W-1:0]    task_priority;
    logic                 last_task;
  } task_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] task_index;
    logic [TICK_W-1:0]  completion_tick;
    logic [TICK_W-1:0]  turnaround;
    logic [TICK_W-1:0]  waiting;
    logic [SUM_W-1:0]   total_turnaround;
    logic [SUM_W-1:0]   total_waiting;
    logic [IDLE_W-1:0]  idle_ticks;
    logic               last_result;
  } result_item_t;

  // classified record handed from the front end to the scheduler engine
  typedef struct packed {
    logic                 store;
    logic                 run;
    logic [ARRIVAL_W-1:0] arrival;
    logic [BURST_W-1:0]   burst;
    logic [PRIO_W-1:0]    prio;
  } cmd_t;

endpackage

// ===== rtl/core/pps_front.sv =====
// front end: accepts task records, normalises burst, drops overflow records
// depends on pps_pkg

module pps_front #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               task_valid,
  output logic               task_ready,
  input  pps_pkg::task_item_t task_data,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output pps_pkg::cmd_t      cmd
);

  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [CNT_W-1:0] loaded;
  logic [CNT_W-1:0] loaded_next;
  logic             room;
  logic             accept;

  assign room = loaded < CNT_W'(MAX_TASKS);

  always_comb begin
    cmd.store   = room;
    cmd.run     = task_data.last_task;
    cmd.arrival = task_data.arrival_tick;
    cmd.burst   = (task_data.burst_ticks == '0) ? pps_pkg::BURST_W'(1) : task_data.burst_ticks;
    cmd.prio    = task_data.task_priority;
  end

  // a full table with no last flag leaves nothing to pass on
  assign cmd_valid  = task_valid && (room || task_data.last_task);
  assign task_ready = cmd_ready || !(room || task_data.last_task);
  assign accept     = task_valid && task_ready;

  always_comb begin
    loaded_next = loaded;
    if (accept) begin
      if (task_data.last_task) begin
        loaded_next = '0;
      end else if (room) begin
        loaded_next = loaded + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else begin
      loaded <= loaded_next;
    end
  end

endmodule

// ===== rtl/core/pps_queue.sv =====
// short command queue between the front end and the scheduler engine
// depends on pps_pkg

module pps_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  pps_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output pps_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = $clog2(pps_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pps_pkg::QUEUE_DEPTH + 1);

  pps_pkg::cmd_t    entries [pps_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             push;
  logic             pop;

  assign push_ready = fill < CNT_W'(pps_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + CNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/pps_back.sv =====
// scheduler engine: task tables, tick loop with serial pick scan, result register
// depends on pps_pkg

module pps_back #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  output logic                  cmd_ready,
  input  pps_pkg::cmd_t         cmd,
  output logic                  result_valid,
  input  logic                  result_ready,
  output pps_pkg::result_item_t result_data
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TW    = pps_pkg::TICK_W;
  localparam int SW    = pps_pkg::SUM_W;
  localparam int IW    = pps_pkg::IDLE_W;
  localparam int AW    = pps_pkg::ARRIVAL_W;
  localparam int BW    = pps_pkg::BURST_W;
  localparam int PW    = pps_pkg::PRIO_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_DRAIN = 6'b000100,
    ST_EXEC  = 6'b001000,
    ST_TALLY = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  typedef struct packed {
    logic [AW-1:0] arrival;
    logic [BW-1:0] burst;
    logic [PW-1:0] prio;
  } entry_t;

  entry_t        task_mem [MAX_TASKS];
  logic [BW-1:0] rem_mem  [MAX_TASKS];

  state_t           state;
  logic [CNT_W-1:0] task_count;
  logic [CNT_W-1:0] done_count;
  logic [TW-1:0]    tick;
  logic [IW-1:0]    idle_count;
  logic [SW-1:0]    sum_turnaround;
  logic [SW-1:0]    sum_waiting;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_valid;
  entry_t           rd_entry;
  logic [BW-1:0]    rd_rem;

  logic             best_found;
  logic [IDX_W-1:0] best_idx;
  logic [AW-1:0]    best_arr;
  logic [BW-1:0]    best_burst;
  logic [PW-1:0]    best_prio;
  logic [BW-1:0]    best_rem;
  logic             pend_found;
  logic [AW-1:0]    min_arr;

  logic [TW-1:0]    tat;
  logic [TW-1:0]    wt;
  logic             out_valid;
  pps_pkg::result_item_t out_data;

  logic             store_we;
  logic             rem_we;
  logic [IDX_W-1:0] rem_waddr;
  logic [BW-1:0]    rem_wdata;
  logic             cand_ready;
  logic             cand_better;
  logic             take;
  logic             pend_upd;
  logic             last_issue;
  logic             last_done;
  logic             out_free;
  logic [TW-1:0]    gap;

  assign cmd_ready    = state == ST_IDLE;
  assign result_valid = out_valid;
  assign result_data  = out_data;
  assign out_free     = !out_valid || result_ready;
  assign store_we     = cmd_valid && cmd_ready && cmd.store;
  assign last_issue   = (CNT_W'(scan_idx) + CNT_W'(1)) == task_count;
  assign last_done    = (done_count + CNT_W'(1)) == task_count;
  assign gap          = {1'b0, min_arr} - tick;

  // candidate compare on the registered read
  assign cand_ready  = ({1'b0, rd_entry.arrival} <= tick) && (rd_rem != '0);
  assign cand_better = !best_found || (rd_entry.prio < best_prio) ||
                       ((rd_entry.prio == best_prio) && (rd_entry.arrival < best_arr));
  assign take        = rd_valid && cand_ready && cand_better;
  assign pend_upd    = rd_valid && (rd_rem != '0) &&
                       (!pend_found || (rd_entry.arrival < min_arr));

  always_comb begin
    rem_we    = 1'b0;
    rem_waddr = task_count[IDX_W-1:0];
    rem_wdata = cmd.burst;
    if (store_we) begin
      rem_we = 1'b1;
    end else if (state == ST_EXEC && best_found) begin
      rem_we    = 1'b1;
      rem_waddr = best_idx;
      rem_wdata = best_rem - BW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      task_mem[task_count[IDX_W-1:0]] <= '{arrival: cmd.arrival, burst: cmd.burst,
                                          prio: cmd.prio};
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
    rd_entry <= task_mem[scan_idx];
    rd_rem   <= rem_mem[scan_idx];
    rd_idx   <= scan_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      task_count     <= '0;
      done_count     <= '0;
      tick           <= '0;
      idle_count     <= '0;
      sum_turnaround <= '0;
      sum_waiting    <= '0;
      scan_idx       <= '0;
      rd_valid       <= 1'b0;
      best_found     <= 1'b0;
      pend_found     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      rd_valid <= state == ST_SCAN;
      if (result_valid && result_ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        best_found <= 1'b1;
        best_idx   <= rd_idx;
        best_arr   <= rd_entry.arrival;
        best_burst <= rd_entry.burst;
        best_prio  <= rd_entry.prio;
        best_rem   <= rd_rem;
      end
      if (pend_upd) begin
        pend_found <= 1'b1;
        min_arr    <= rd_entry.arrival;
      end
      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            if (cmd.store) begin
              task_count <= task_count + CNT_W'(1);
            end
            if (cmd.run) begin
              state      <= ST_SCAN;
              scan_idx   <= '0;
              best_found <= 1'b0;
              pend_found <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          scan_idx <= scan_idx + IDX_W'(1);
          if (last_issue) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_EXEC;
        end
        ST_EXEC: begin
          if (best_found) begin
            tick <= tick + TW'(1);
            tat  <= tick + TW'(1) - {1'b0, best_arr};
            if (best_rem == BW'(1)) begin
              state <= ST_TALLY;
            end else begin
              state      <= ST_SCAN;
              scan_idx   <= '0;
              best_found <= 1'b0;
              pend_found <= 1'b0;
            end
          end else if (pend_found) begin
            // nothing ready: jump to the next arrival, skipped ticks are idle
            idle_count <= idle_count + gap[IW-1:0];
            tick       <= {1'b0, min_arr};
            state      <= ST_SCAN;
            scan_idx   <= '0;
            pend_found <= 1'b0;
          end else begin
            state          <= ST_IDLE;
            task_count     <= '0;
            done_count     <= '0;
            tick           <= '0;
            idle_count     <= '0;
            sum_turnaround <= '0;
            sum_waiting    <= '0;
          end
        end
        ST_TALLY: begin
          wt             <= tat - TW'(best_burst);
          sum_turnaround <= sum_turnaround + SW'(tat);
          state          <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid                 <= 1'b1;
            out_data.task_index       <= pps_pkg::INDEX_W'(best_idx);
            out_data.completion_tick  <= tick;
            out_data.turnaround       <= tat;
            out_data.waiting          <= wt;
            out_data.total_turnaround <= sum_turnaround;
            out_data.total_waiting    <= sum_waiting + SW'(wt);
            out_data.idle_ticks       <= idle_count;
            out_data.last_result      <= last_done;
            if (last_done) begin
              state          <= ST_IDLE;
              task_count     <= '0;
              done_count     <= '0;
              tick           <= '0;
              idle_count     <= '0;
              sum_turnaround <= '0;
              sum_waiting    <= '0;
            end else begin
              sum_waiting <= sum_waiting + SW'(wt);
              done_count  <= done_count + CNT_W'(1);
              state       <= ST_SCAN;
              scan_idx    <= '0;
              best_found  <= 1'b0;
              pend_found  <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    done_count <= task_count)
    else $error("completions exceed loaded tasks");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> (tick == '0 && idle_count == '0 && done_count == '0))
    else $error("run state not cleared while idle");

  a_tally_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_TALLY |-> (best_found && best_rem == BW'(1)))
    else $error("tally without a finishing task");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && out_free && last_done) |=>
      (state == ST_IDLE && result_valid && result_data.last_result))
    else $error("final completion did not end the run");

endmodule

// ===== rtl/core/preemptive_priority_scheduler_core.sv =====
// top level of the preemptive priority scheduler core
// depends on pps_pkg, pps_front, pps_queue, pps_back
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+---------------------
//   task     | in        | task_valid / task_ready     | pps_pkg::task_item_t
//   result   | out       | result_valid / result_ready | pps_pkg::result_item_t
//
// while the engine idles, task records load one per cycle through a two-entry
// queue into the tables; a run does a serial pick scan over the tables
//   for every scheduled tick and idle jump, and a tally and emit per completion
// input stalls once the queue fills during a run; results wait in one register
// synchronous active-high reset; tables are not cleared and need no sweep

module preemptive_priority_scheduler_core #(
  parameter int MAX_TASKS = pps_pkg::MAX_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  task_valid,
  output logic                  task_ready,
  input  pps_pkg::task_item_t   task_data,
  output logic                  result_valid,
  input  logic                  result_ready,
  output pps_pkg::result_item_t result_data
);

  logic          front_valid;
  logic          front_ready;
  pps_pkg::cmd_t front_cmd;
  logic          back_valid;
  logic          back_ready;
  pps_pkg::cmd_t back_cmd;

  pps_front #(
    .MAX_TASKS(MAX_TASKS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .task_valid(task_valid),
    .task_ready(task_ready),
    .task_data (task_data),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  pps_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(front_valid),
    .push_ready(front_ready),
    .push_cmd  (front_cmd),
    .pop_valid (back_valid),
    .pop_ready (back_ready),
    .pop_cmd   (back_cmd)
  );

  pps_back #(
    .MAX_TASKS(MAX_TASKS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (back_valid),
    .cmd_ready   (back_ready),
    .cmd         (back_cmd),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result_data (result_data)
  );

endmodule
